// ===== design/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, also during reset
`define CHK_RESET(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and GF(2^8) helpers for the AES-128 encrypt pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int StageCnt  = NumRounds + 1;  // initial add plus ten rounds
  localparam int CfgIdxW   = 1;

  typedef logic [127:0] blk_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  localparam logic [255:0][7:0] SBOX = {
    8'h16, 8'hbb, 8'h54, 8'hb0, 8'h0f, 8'h2d, 8'h99, 8'h41,
    8'h68, 8'h42, 8'he6, 8'hbf, 8'h0d, 8'h89, 8'ha1, 8'h8c,
    8'hdf, 8'h28, 8'h55, 8'hce, 8'he9, 8'h87, 8'h1e, 8'h9b,
    8'h94, 8'h8e, 8'hd9, 8'h69, 8'h11, 8'h98, 8'hf8, 8'he1,
    8'h9e, 8'h1d, 8'hc1, 8'h86, 8'hb9, 8'h57, 8'h35, 8'h61,
    8'h0e, 8'hf6, 8'h03, 8'h48, 8'h66, 8'hb5, 8'h3e, 8'h70,
    8'h8a, 8'h8b, 8'hbd, 8'h4b, 8'h1f, 8'h74, 8'hdd, 8'he8,
    8'hc6, 8'hb4, 8'ha6, 8'h1c, 8'h2e, 8'h25, 8'h78, 8'hba,
    8'h08, 8'hae, 8'h7a, 8'h65, 8'hea, 8'hf4, 8'h56, 8'h6c,
    8'ha9, 8'h4e, 8'hd5, 8'h8d, 8'h6d, 8'h37, 8'hc8, 8'he7,
    8'h79, 8'he4, 8'h95, 8'h91, 8'h62, 8'hac, 8'hd3, 8'hc2,
    8'h5c, 8'h24, 8'h06, 8'h49, 8'h0a, 8'h3a, 8'h32, 8'he0,
    8'hdb, 8'h0b, 8'h5e, 8'hde, 8'h14, 8'hb8, 8'hee, 8'h46,
    8'h88, 8'h90, 8'h2a, 8'h22, 8'hdc, 8'h4f, 8'h81, 8'h60,
    8'h73, 8'h19, 8'h5d, 8'h64, 8'h3d, 8'h7e, 8'ha7, 8'hc4,
    8'h17, 8'h44, 8'h97, 8'h5f, 8'hec, 8'h13, 8'h0c, 8'hcd,
    8'hd2, 8'hf3, 8'hff, 8'h10, 8'h21, 8'hda, 8'hb6, 8'hbc,
    8'hf5, 8'h38, 8'h9d, 8'h92, 8'h8f, 8'h40, 8'ha3, 8'h51,
    8'ha8, 8'h9f, 8'h3c, 8'h50, 8'h7f, 8'h02, 8'hf9, 8'h45,
    8'h85, 8'h33, 8'h4d, 8'h43, 8'hfb, 8'haa, 8'hef, 8'hd0,
    8'hcf, 8'h58, 8'h4c, 8'h4a, 8'h39, 8'hbe, 8'hcb, 8'h6a,
    8'h5b, 8'hb1, 8'hfc, 8'h20, 8'hed, 8'h00, 8'hd1, 8'h53,
    8'h84, 8'h2f, 8'he3, 8'h29, 8'hb3, 8'hd6, 8'h3b, 8'h52,
    8'ha0, 8'h5a, 8'h6e, 8'h1b, 8'h1a, 8'h2c, 8'h83, 8'h09,
    8'h75, 8'hb2, 8'h27, 8'heb, 8'he2, 8'h80, 8'h12, 8'h07,
    8'h9a, 8'h05, 8'h96, 8'h18, 8'hc3, 8'h23, 8'hc7, 8'h04,
    8'h15, 8'h31, 8'hd8, 8'h71, 8'hf1, 8'he5, 8'ha5, 8'h34,
    8'hcc, 8'hf7, 8'h3f, 8'h36, 8'h26, 8'h93, 8'hfd, 8'hb7,
    8'hc0, 8'h72, 8'ha4, 8'h9c, 8'haf, 8'ha2, 8'hd4, 8'had,
    8'hf0, 8'h47, 8'h59, 8'hfa, 8'h7d, 8'hc9, 8'h82, 8'hca,
    8'h76, 8'hab, 8'hd7, 8'hfe, 8'h2b, 8'h67, 8'h01, 8'h30,
    8'hc5, 8'h6f, 8'h6b, 8'hf2, 8'h7b, 8'h77, 8'h7c, 8'h63
  };

  // round constants, one per expansion step
  localparam logic [9:0][7:0] RCON = {
    8'h36, 8'h1b, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
  };

  // byte n of a block, byte 0 on top
  function automatic logic [7:0] get_byte(input blk_t b, input int n);
    return b[127 - 8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes and ShiftRows together
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c + 1);
      a2  = get_byte(s, 4*c + 2);
      a3  = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // one step of the key schedule
  function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ===== design/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// aes_key_sched
// Registered key schedule: each round key is registered from the one before
// it, so after a key write the keys settle in turn and hold until the next write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes_key_sched import aes_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire blk_t                     key,
  output wire blk_t [StageCnt-1:0]      round_keys
);

  // round key 0 is the key itself; each later key follows from the one above
  assign round_keys[0] = key;

  for (genvar i = 1; i < StageCnt; i++) begin : g_rk
    blk_t rk;
    always_ff @(posedge clk) begin
      if (rst) begin
        rk <= '0;
      end else begin
        rk <= next_key(round_keys[i-1], RCON[i-1]);
      end
    end
    assign round_keys[i] = rk;
  end

endmodule
`default_nettype wire

// ===== design/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round
// One pipeline stage of the cipher: one round plus its key add, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes_round import aes_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic last_rnd,
  input  wire logic in_vld,
  input  wire blk_t in_blk,
  input  wire blk_t rkey,
  output logic      out_vld,
  output blk_t      out_blk
);

  blk_t sub;
  blk_t mixed;

  // round datapath; the last round skips MixColumns
  always_comb begin
    sub   = sub_shift(in_blk);
    mixed = last_rnd ? sub : mix_columns(sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blk <= mixed ^ rkey;
    end
  end

endmodule
`default_nettype wire

// ===== design/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// Fully unrolled AES-128 encrypt pipeline, one block per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//   channel  | signals                          | direction
//   input    | in_valid in_ready plain_*        | in
//   output   | out_valid out_ready cipher_*     | out
//   config   | cfg_valid cfg_ready cfg_index/data | in
//
// Eleven register stages (initial key add plus ten rounds); one block enters
// each cycle. The pipeline advances as a whole, stalled only when the last
// stage holds a result that is not taken. After a key write the round keys
// settle stage by stage in the key schedule, each just ahead of the first
// block that needs it; config is taken only while the pipe is empty. Reset
// clears valid bits and keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_encrypt import aes_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [63:0]        plain_high,
  input  wire logic [63:0]        plain_low,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             cipher_high,
  output logic [63:0]             cipher_low,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  blk_t [StageCnt-1:0] rkeys;
  wire logic [StageCnt-1:0] vld;
  wire blk_t [StageCnt-1:0] blk;
  logic s0_vld;
  blk_t s0_blk;
  logic adv;

  // key writes only into an empty pipe
  assign cfg_ready = !(|vld);

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_key_sched u_ks (
    .clk        (clk),
    .rst        (rst),
    .key        ({key_high, key_low}),
    .round_keys (rkeys)
  );

  // whole pipe moves unless the output holds an untaken result
  assign adv      = !vld[StageCnt-1] || out_ready;
  assign in_ready = adv;

  // stage 0: initial key add
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_blk <= {plain_high, plain_low} ^ rkeys[0];
    end
  end

  assign vld[0] = s0_vld;
  assign blk[0] = s0_blk;

  // ten round stages
  for (genvar i = 1; i < StageCnt; i++) begin : g_rnd
    aes_round u_rnd (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .last_rnd (i == StageCnt - 1),
      .in_vld   (vld[i-1]),
      .in_blk   (blk[i-1]),
      .rkey     (rkeys[i]),
      .out_vld  (vld[i]),
      .out_blk  (blk[i])
    );
  end

  assign out_valid   = vld[StageCnt-1];
  assign cipher_high = blk[StageCnt-1][127:64];
  assign cipher_low  = blk[StageCnt-1][63:0];

endmodule
`default_nettype wire

// ===== design/aes_checker.sv =====
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks on the encrypt pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aes_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] cipher_high,
  input wire logic [63:0] cipher_low
);

  logic [127:0] cipher;

  assign cipher = {cipher_high, cipher_low};

  `CHK_ALWAYS(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(cipher), "result changed")
  `CHK_ALWAYS(a_ready_free, !out_valid |-> in_ready, "input blocked with empty output")
  `CHK_ALWAYS(a_ready_out, out_ready |-> in_ready, "input blocked while output drains")
  `CHK_RESET(a_reset_clear, rst |=> !out_valid, "result after reset")

endmodule

bind aes128_block_encrypt aes_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cipher_high (cipher_high),
  .cipher_low  (cipher_low)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the AES-128 encrypt pipeline against a behavioral cipher model.
// Directed blocks (a known-answer vector, all-zero / all-one patterns) and
// random blocks are sent under several key settings and idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import aes_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] plain_high = '0;
  logic [63:0] plain_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  aes128_block_encrypt u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .plain_high(plain_high), .plain_low(plain_low),
    .out_valid(out_valid), .out_ready(out_ready),
    .cipher_high(cipher_high), .cipher_low(cipher_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // cipher model state
  logic [63:0]  key_hi_q = '0;
  logic [63:0]  key_lo_q = '0;
  logic [127:0] cipher_q[$];

  int errors = 0;
  int blocks_sent = 0;
  int blocks_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  localparam logic [7:0] SB[256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // full FIPS-197 encryption, byte 0 at [0]
  function automatic logic [127:0] encrypt_block(logic [127:0] key, logic [127:0] pt);
    logic [7:0] rk[176];
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [7:0] t0, t1, t2, t3, sv, rc, a0, a1, a2, a3, al;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      st[i] = pt[127 - 8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      t0 = rk[i-4]; t1 = rk[i-3]; t2 = rk[i-2]; t3 = rk[i-1];
      if (i % 16 == 0) begin
        sv = t0;
        t0 = SB[t1] ^ rc; t1 = SB[t2]; t2 = SB[t3]; t3 = SB[sv];
        rc = gf_dbl(rc);
      end
      rk[i] = rk[i-16] ^ t0; rk[i+1] = rk[i-15] ^ t1;
      rk[i+2] = rk[i-14] ^ t2; rk[i+3] = rk[i-13] ^ t3;
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[r + 4*c] = SB[st[r + 4*((c + r) % 4)]];
      st = tmp;
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // send one block; valid stays high across back-to-back transfers
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    plain_high <= hi;
    plain_low  <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_q.push_back(encrypt_block({key_hi_q, key_lo_q}, {hi, lo}));
    blocks_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected result has come back, then let the pipe settle
  task automatic drain();
    int guard;
    guard = 0;
    end_burst();
    while (cipher_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * StageCnt + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    @(posedge clk);
  endtask

  task automatic set_key(logic [63:0] hi, logic [63:0] lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LOW, lo);
    repeat (StageCnt + 2) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected transfer", cipher_high, cipher_low);
      end else begin
        want = cipher_q.pop_front();
        if (cipher_high !== want[127:64]) report_mismatch("cipher_high", cipher_high, want[127:64]);
        if (cipher_low !== want[63:0]) report_mismatch("cipher_low", cipher_low, want[63:0]);
      end
      blocks_seen++;
    end
  end

  // receiver ready, random stalls or a long hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (recv_stall_pct > 0) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_known_answer();
    // FIPS-197 appendix C.1 vector, then zero and all-one keys
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    set_key('0, '0);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    drain();
    set_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_key({$urandom, $urandom}, {$urandom, $urandom});
    for (int i = 0; i < count; i++) send_block({$urandom, $urandom}, {$urandom, $urandom});
    drain();
  endtask

  task automatic test_backpressure();
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        n = 0;
        while (n < 60) begin
          @(posedge clk);
          n++;
        end
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_block({$urandom, $urandom}, {$urandom, $urandom});
    join
    // sender pauses until every result is back
    drain();
    for (int i = 0; i < 10; i++) send_block({$urandom, $urandom}, {$urandom, $urandom});
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_answer();
    test_random_phase(0, 0, 120);
    test_random_phase(68, 0, 110);
    test_random_phase(0, 68, 110);
    test_random_phase(38, 38, 110);
    test_backpressure();
    $display("Sent %0d blocks under 7 keys, including all-zero and all-one keys,", blocks_sent);
    $display("with idle, stall and full-pipe hold-off phases; %0d results checked.", blocks_seen);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("aes128_block_encrypt: match");
    end else begin
      $display("aes128_block_encrypt: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("aes128_block_encrypt: mismatch");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/aes_pkg.sv
design/aes_key_sched.sv
design/aes_round.sv
design/aes128_block_encrypt.sv
design/aes_checker.sv
dv/testbench.sv
